@@ design/tpfq_pkg.sv @@
// shared types and codes of the pending forward queue
package tpfq_pkg;

    typedef enum logic [1:0] {
        OP_ARRIVAL   = 2'd0,
        OP_DUPLICATE = 2'd1,
        OP_FIRING    = 2'd2,
        OP_TICK      = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        KIND_NONE     = 3'd0,
        KIND_FORWARD  = 3'd1,
        KIND_SUPPRESS = 3'd2,
        KIND_EXPIRED  = 3'd3,
        KIND_REJECTED = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        TCMD_NONE  = 2'd0,
        TCMD_START = 2'd1,
        TCMD_STOP  = 2'd2
    } tcmd_t;

    localparam logic [1:0] REG_MAX_DELAY = 2'd0;
    localparam logic [1:0] REG_ONE_PER_FIRING = 2'd1;
    localparam logic [1:0] REG_HEAD_OF_LINE = 2'd2;
    localparam logic [1:0] REG_DUP_THRESHOLD = 2'd3;

    localparam int MAX_RESULTS = 16;

    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] originator;
        logic [7:0]  seq_no;
        logic [15:0] packet_handle;
    } request_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] out_handle;
        logic        consistent_event;
        logic [1:0]  timer_command;
        logic        last;
    } result_t;

endpackage

@@ design/trickle_pending_forward_queue.sv @@
// top level of the pending forward queue
//
// Holds packets waiting for the trickle timer to let them go.
// s_axis carries requests: op in tuser; originator, sequence number and
// handle in tdata. m_axis carries results: kind in tuser; handle,
// consistent event and timer command in tdata; m_axis_tlast marks the
// final result of a request.
// cfg_* writes the four registers (index 0 max_delay, 1 one_per_firing,
// 2 head_of_line_only, 3 duplicate_threshold); the user writes them only
// while the block is idle, which the block itself does not enforce.
// A two-entry input queue decouples the request side from the sequencer.
// The sequencer handles one request at a time and takes the next only when
// its result register is free or being read: an arrival registers its
// result in the cycle after it is taken, a duplicate compares one queue
// entry a cycle, and a firing or tick gives up to 16 results, each read
// from the entry memory in ST_READ and emitted in ST_EMIT.
// Reset empties the queue, zeroes time, stops the timer and loads the
// register defaults; entries need no clearing.
// When m_axis_tready is low the sequencer holds its result and waits; the
// input queue keeps taking requests until it fills.
module trickle_pending_forward_queue import tpfq_pkg::*; #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TIME_WIDTH  = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,   // originator, seq_no, packet_handle
    input  logic [1:0]  s_axis_tuser,   // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // out_handle, consistent_event, timer_command, pad
    output logic [2:0]  m_axis_tuser,   // kind
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    request_t    s_req;
    request_t    q_req;
    result_t     res;
    logic        q_valid;
    logic        q_ready;
    logic [15:0] max_delay_reg;
    logic        one_per_firing_reg;
    logic        head_of_line_reg;
    logic [15:0] dup_threshold_reg;

    assign s_req.op            = s_axis_tuser;
    assign s_req.originator    = s_axis_tdata[63:0];
    assign s_req.seq_no        = s_axis_tdata[71:64];
    assign s_req.packet_handle = s_axis_tdata[87:72];
    assign cfg_ready           = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_delay_reg      <= 16'd500;
            one_per_firing_reg <= 1'b0;
            head_of_line_reg   <= 1'b0;
            dup_threshold_reg  <= 16'd0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_MAX_DELAY:      max_delay_reg <= cfg_data;
                REG_ONE_PER_FIRING: one_per_firing_reg <= cfg_data[0];
                REG_HEAD_OF_LINE:   head_of_line_reg <= cfg_data[0];
                REG_DUP_THRESHOLD:  dup_threshold_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    tpfq_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_req    (s_req),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_req   (q_req)
    );

    tpfq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TIME_WIDTH  (TIME_WIDTH)
    ) u_back (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .in_valid            (q_valid),
        .in_ready            (q_ready),
        .in_req              (q_req),
        .max_delay           (max_delay_reg),
        .one_per_firing      (one_per_firing_reg),
        .head_of_line_only   (head_of_line_reg),
        .duplicate_threshold (dup_threshold_reg),
        .out_valid           (m_axis_tvalid),
        .out_ready           (m_axis_tready),
        .out_res             (res)
    );

    assign m_axis_tdata = {5'b00000, res.timer_command, res.consistent_event,
                           res.out_handle};
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last;
endmodule

@@ design/tpfq_front.sv @@
// input side: takes requests into a two-entry queue
module tpfq_front import tpfq_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  request_t in_req,
    output logic     out_valid,
    input  logic     out_ready,
    output request_t out_req
);
    request_t   slot_reg [2];
    logic [1:0] count_reg;
    logic       rd_reg;
    logic       wr_reg;
    logic       push;
    logic       pop;

    assign in_ready  = count_reg != 2'd2;
    assign out_valid = count_reg != 2'd0;
    assign out_req   = slot_reg[rd_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_reg] <= in_req;
        end
        if (!aresetn) begin
            count_reg <= 2'd0;
            rd_reg    <= 1'b0;
            wr_reg    <= 1'b0;
        end else begin
            if (push) wr_reg <= ~wr_reg;
            if (pop) rd_reg <= ~rd_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

@@ design/tpfq_back.sv @@
// queue state and sequencer that executes one request at a time
module tpfq_back import tpfq_pkg::*; #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TIME_WIDTH  = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  request_t    in_req,
    input  logic [15:0] max_delay,
    input  logic        one_per_firing,
    input  logic        head_of_line_only,
    input  logic [15:0] duplicate_threshold,
    output logic        out_valid,
    input  logic        out_ready,
    output result_t     out_res
);
    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int RW = $clog2(MAX_RESULTS + 1);

    typedef enum logic [2:0] {
        ST_IDLE, ST_SEARCH, ST_READ, ST_EMIT, ST_WAIT
    } state_t;

    logic [63:0]           mem_orig [QUEUE_DEPTH];
    logic [7:0]            mem_seq [QUEUE_DEPTH];
    logic [TIME_WIDTH-1:0] mem_dl [QUEUE_DEPTH];
    logic [15:0]           mem_seen [QUEUE_DEPTH];
    logic [15:0]           mem_handle [QUEUE_DEPTH];

    state_t                state_reg;
    request_t              req_reg;
    logic [IW-1:0]         head_reg;
    logic [CW-1:0]         count_reg;
    logic [TIME_WIDTH-1:0] now_reg;
    logic                  running_reg;
    logic [CW-1:0]         idx_reg;
    logic                  found_reg;
    logic                  ev_reg;
    logic [RW-1:0]         nres_reg;
    result_t               res_reg;
    logic                  res_valid_reg;

    // registered read of the head entry
    logic [15:0]           rd_handle_reg;
    logic [15:0]           rd_seen_reg;
    logic [TIME_WIDTH-1:0] rd_dl_reg;
    // deadline of the entry behind the head, to know whether an expiry is the last one
    logic [TIME_WIDTH-1:0] rd_next_dl_reg;
    // registered read of the search entry
    logic [63:0]           sr_orig_reg;
    logic [7:0]            sr_seq_reg;
    logic [15:0]           sr_seen_reg;
    logic [IW-1:0]         sr_slot_reg;
    logic                  sr_valid_reg;

    logic [IW-1:0]         tail_slot;
    logic [IW-1:0]         srch_slot;
    logic [IW-1:0]         next_slot;
    logic                  sup;
    logic                  expired;
    logic [TIME_WIDTH-1:0] tdiff;
    logic                  next_expired;
    logic [TIME_WIDTH-1:0] next_tdiff;
    logic                  match;
    logic                  room;

    function automatic logic [IW-1:0] wrap_add(logic [IW-1:0] a, logic [CW-1:0] b);
        logic [CW:0] s;
        s = {{(CW+1-IW){1'b0}}, a} + {1'b0, b};
        if (s >= (CW+1)'(QUEUE_DEPTH)) s = s - (CW+1)'(QUEUE_DEPTH);
        return s[IW-1:0];
    endfunction

    assign tail_slot    = wrap_add(head_reg, count_reg);
    assign srch_slot    = wrap_add(head_reg, idx_reg);
    assign next_slot    = wrap_add(head_reg, CW'(1));
    assign sup          = duplicate_threshold != 16'd0 && rd_seen_reg >= duplicate_threshold;
    assign tdiff        = now_reg - rd_dl_reg;
    assign expired      = !tdiff[TIME_WIDTH-1];
    assign next_tdiff   = now_reg - rd_next_dl_reg;
    assign next_expired = !next_tdiff[TIME_WIDTH-1];
    assign match        = sr_orig_reg == req_reg.originator && sr_seq_reg == req_reg.seq_no;
    assign room         = !res_valid_reg || out_ready;
    assign in_ready     = state_reg == ST_IDLE && room;
    assign out_valid    = res_valid_reg;
    assign out_res      = res_reg;

    always_ff @(posedge aclk) begin
        rd_handle_reg  <= mem_handle[head_reg];
        rd_seen_reg    <= mem_seen[head_reg];
        rd_dl_reg      <= mem_dl[head_reg];
        rd_next_dl_reg <= mem_dl[next_slot];
        sr_orig_reg    <= mem_orig[srch_slot];
        sr_seq_reg     <= mem_seq[srch_slot];
        sr_seen_reg    <= mem_seen[srch_slot];
        sr_slot_reg    <= srch_slot;
        if (in_valid && in_ready && in_req.op == OP_ARRIVAL
                && count_reg < CW'(QUEUE_DEPTH)) begin
            mem_orig[tail_slot]   <= in_req.originator;
            mem_seq[tail_slot]    <= in_req.seq_no;
            mem_dl[tail_slot]     <= now_reg + TIME_WIDTH'(max_delay);
            mem_seen[tail_slot]   <= 16'd1;
            mem_handle[tail_slot] <= in_req.packet_handle;
        end else if (state_reg == ST_SEARCH && sr_valid_reg && !found_reg && match
                && sr_seen_reg != 16'hFFFF) begin
            mem_seen[sr_slot_reg] <= sr_seen_reg + 16'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            now_reg       <= '0;
            running_reg   <= 1'b0;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            ev_reg        <= 1'b0;
            nres_reg      <= '0;
            res_valid_reg <= 1'b0;
            sr_valid_reg  <= 1'b0;
        end else begin
            if (res_valid_reg && out_ready) res_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_valid && room) begin
                        req_reg   <= in_req;
                        nres_reg  <= '0;
                        idx_reg   <= '0;
                        found_reg <= 1'b0;
                        unique case (op_t'(in_req.op))
                            OP_ARRIVAL: begin
                                res_reg.consistent_event <= 1'b0;
                                res_reg.last <= 1'b1;
                                res_reg.timer_command <= TCMD_NONE;
                                res_valid_reg <= 1'b1;
                                if (count_reg >= CW'(QUEUE_DEPTH)) begin
                                    res_reg.kind <= KIND_REJECTED;
                                    res_reg.out_handle <= in_req.packet_handle;
                                end else begin
                                    res_reg.kind <= KIND_NONE;
                                    res_reg.out_handle <= 16'd0;
                                    count_reg <= count_reg + CW'(1);
                                    if (!running_reg) begin
                                        running_reg <= 1'b1;
                                        res_reg.timer_command <= TCMD_START;
                                    end
                                end
                                state_reg <= ST_WAIT;
                            end
                            OP_DUPLICATE: begin
                                sr_valid_reg <= 1'b0;
                                state_reg <= ST_SEARCH;
                            end
                            OP_FIRING: state_reg <= ST_READ;
                            OP_TICK: begin
                                now_reg <= now_reg + TIME_WIDTH'(1);
                                state_reg <= ST_READ;
                            end
                            default: state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_SEARCH: begin
                    // one entry compared per cycle; its read is registered before the comparison
                    if (sr_valid_reg && !found_reg && match) begin
                        found_reg <= 1'b1;
                    end
                    if (sr_valid_reg && sr_slot_reg == head_reg && !found_reg) begin
                        ev_reg <= match;
                    end
                    if (!running_reg || idx_reg >= count_reg
                            || (sr_valid_reg && match) || found_reg) begin
                        // head comparison needed for head-of-line mode
                        if (running_reg) begin
                            if (!head_of_line_only) ev_reg <= 1'b1;
                            else if (count_reg == '0) ev_reg <= 1'b0;
                            else if (!(sr_valid_reg && sr_slot_reg == head_reg)
                                     && idx_reg != '0) begin
                                ev_reg <= ev_reg;
                            end
                        end else begin
                            ev_reg <= 1'b0;
                        end
                        sr_valid_reg <= 1'b0;
                        state_reg <= ST_EMIT;
                    end else begin
                        sr_valid_reg <= 1'b1;
                        idx_reg <= idx_reg + CW'(1);
                    end
                end
                ST_READ: begin
                    // head entry lands in read registers for the next cycle
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (room) begin
                        res_reg.consistent_event <= 1'b0;
                        res_reg.timer_command    <= TCMD_NONE;
                        res_reg.last             <= 1'b0;
                        res_valid_reg            <= 1'b1;
                        unique case (op_t'(req_reg.op))
                            OP_DUPLICATE: begin
                                res_reg.kind <= KIND_NONE;
                                res_reg.out_handle <= 16'd0;
                                res_reg.consistent_event <= running_reg &&
                                    (!head_of_line_only || (count_reg != '0 && ev_reg));
                                res_reg.last <= 1'b1;
                                state_reg <= ST_WAIT;
                            end
                            OP_FIRING: begin
                                if (running_reg && count_reg != '0
                                        && nres_reg < RW'(MAX_RESULTS)) begin
                                    res_reg.kind <= sup ? KIND_SUPPRESS : KIND_FORWARD;
                                    res_reg.out_handle <= rd_handle_reg;
                                    head_reg <= wrap_add(head_reg, CW'(1));
                                    count_reg <= count_reg - CW'(1);
                                    nres_reg <= nres_reg + RW'(1);
                                    if ((one_per_firing && !sup) || count_reg == CW'(1)
                                            || nres_reg == RW'(MAX_RESULTS - 1)) begin
                                        res_reg.last <= 1'b1;
                                        if (count_reg == CW'(1)) begin
                                            running_reg <= 1'b0;
                                            res_reg.timer_command <= TCMD_STOP;
                                        end
                                        state_reg <= ST_WAIT;
                                    end else begin
                                        state_reg <= ST_READ;
                                    end
                                end else begin
                                    res_reg.kind <= KIND_NONE;
                                    res_reg.out_handle <= 16'd0;
                                    res_reg.last <= 1'b1;
                                    if (running_reg) begin
                                        running_reg <= 1'b0;
                                        res_reg.timer_command <= TCMD_STOP;
                                    end
                                    state_reg <= ST_WAIT;
                                end
                            end
                            default: begin
                                if (count_reg != '0 && expired) begin
                                    res_reg.kind <= KIND_EXPIRED;
                                    res_reg.out_handle <= rd_handle_reg;
                                    head_reg <= wrap_add(head_reg, CW'(1));
                                    count_reg <= count_reg - CW'(1);
                                    nres_reg <= nres_reg + RW'(1);
                                    // final if queue empties, next head survives or 16 are out
                                    if (count_reg == CW'(1) || !next_expired
                                            || nres_reg == RW'(MAX_RESULTS - 1)) begin
                                        res_reg.last <= 1'b1;
                                        if (count_reg == CW'(1) && running_reg) begin
                                            running_reg <= 1'b0;
                                            res_reg.timer_command <= TCMD_STOP;
                                        end
                                        state_reg <= ST_WAIT;
                                    end else begin
                                        state_reg <= ST_READ;
                                    end
                                end else begin
                                    res_reg.kind <= KIND_NONE;
                                    res_reg.out_handle <= 16'd0;
                                    res_reg.last <= 1'b1;
                                    if (count_reg == '0 && running_reg) begin
                                        running_reg <= 1'b0;
                                        res_reg.timer_command <= TCMD_STOP;
                                    end
                                    state_reg <= ST_WAIT;
                                end
                            end
                        endcase
                    end
                end
                ST_WAIT: begin
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
